// ----- hw/rtl/svs_pkg.sv -----
`timescale 1ns / 1ps

package svs_pkg;

   // Width and field constants of the link
   localparam int ValveCountDefault = 8;
   localparam int ReplyBits         = 16;
   localparam int OpcodeBits        = 4;
   localparam int SampleWidth       = 10;
   localparam int ShiftWidth        = 16;
   localparam int IndexWidth        = 5;
   localparam int ShownValves       = 8;

   // Opcodes sent by the master
   localparam logic [OpcodeBits-1:0] OpSetValves    = 4'b0001;
   localparam logic [OpcodeBits-1:0] OpReadPressure = 4'b0010;

   // Reply words
   localparam logic [ShiftWidth-1:0] SampleMask  = 16'h0FFF;
   localparam logic [ShiftWidth-1:0] InvalidWord = 16'h8000;

   // Link phases; unused codes behave as the sync hunt
   typedef enum logic [3:0] {
      PH_HUNT       = 4'd0,
      PH_SYNC_UP    = 4'd1,
      PH_SYNC_DOWN  = 4'd2,
      PH_OP_UP      = 4'd3,
      PH_OP_DOWN    = 4'd4,
      PH_VALVE_UP   = 4'd5,
      PH_VALVE_DOWN = 4'd6,
      PH_SEND_UP    = 4'd7,
      PH_SEND_DOWN  = 4'd8
   } phase_type;

   // One sample of the pins, packed as on req_tdata (lowest field last)
   typedef struct packed {
      logic                   pressure_valid;
      logic [SampleWidth-1:0] pressure_sample;
      logic                   data_line;
      logic                   clock_line;
      logic                   sync_line;
   } req_item_type;

   // One result, packed as on rsp_tdata (lowest field last)
   typedef struct packed {
      logic                   in_sync;
      logic [ShownValves-1:0] valve_states;
      logic                   data_out;
      logic                   ack_clock;
   } rsp_item_type;

   localparam int ReqBits      = $bits(req_item_type);
   localparam int RspBits      = $bits(rsp_item_type);
   localparam int ReqDataWidth = ((ReqBits + 7) / 8) * 8;
   localparam int RspDataWidth = ((RspBits + 7) / 8) * 8;

endpackage

// ----- hw/rtl/svs_core.sv -----
`timescale 1ns / 1ps

module svs_core #(
   parameter int VALVE_COUNT = svs_pkg::ValveCountDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  svs_pkg::req_item_type item,
   output svs_pkg::rsp_item_type result
);

   svs_pkg::phase_type                phase_ff, phase_in;
   logic [svs_pkg::IndexWidth-1:0]    index_ff, index_in;
   logic [svs_pkg::ShiftWidth-1:0]    shift_ff, shift_in;
   logic [VALVE_COUNT-1:0]            valve_ff, valve_in;
   logic                              clk_out_ff, clk_out_in;
   logic                              dat_out_ff, dat_out_in;

   logic                              sync_l, clk_l, dat_l;
   logic [svs_pkg::ShiftWidth-1:0]    shift_set;
   logic [svs_pkg::ShiftWidth-1:0]    reply_word;
   logic [svs_pkg::IndexWidth-1:0]    index_inc;
   logic                              in_sync;

   assign sync_l = item.sync_line;
   assign clk_l  = item.clock_line;
   assign dat_l  = item.data_line;

   // Shift word with the current bit set when the data lane is active
   always_comb begin
      shift_set = shift_ff;
      if (dat_l && !index_ff[svs_pkg::IndexWidth-1]) begin
         shift_set[index_ff[svs_pkg::IndexWidth-2:0]] = 1'b1;
      end
   end

   assign index_inc  = index_ff + svs_pkg::IndexWidth'(1);
   assign reply_word = item.pressure_valid ?
                       ({6'd0, item.pressure_sample} & svs_pkg::SampleMask) :
                       svs_pkg::InvalidWord;

   // Next state of the link for one pin sample
   always_comb begin
      phase_in   = phase_ff;
      index_in   = index_ff;
      shift_in   = shift_ff;
      valve_in   = valve_ff;
      clk_out_in = clk_out_ff;
      dat_out_in = dat_out_ff;
      case (phase_ff)
         svs_pkg::PH_SYNC_UP: begin
            if (clk_l) begin
               clk_out_in = 1'b1;
               phase_in   = svs_pkg::PH_SYNC_DOWN;
            end else if (!sync_l || dat_l) begin
               phase_in = svs_pkg::PH_HUNT;
            end
         end
         svs_pkg::PH_SYNC_DOWN: begin
            if (clk_l) begin
               if (dat_l) phase_in = svs_pkg::PH_HUNT;
            end else if (sync_l) begin
               phase_in = svs_pkg::PH_HUNT;
            end else begin
               clk_out_in = 1'b0;
               phase_in   = svs_pkg::PH_OP_UP;
               index_in   = '0;
               shift_in   = '0;
            end
         end
         svs_pkg::PH_OP_UP, svs_pkg::PH_VALVE_UP: begin
            if (clk_l) begin
               shift_in   = shift_set;
               index_in   = index_inc;
               clk_out_in = 1'b1;
               phase_in   = (phase_ff == svs_pkg::PH_OP_UP) ? svs_pkg::PH_OP_DOWN :
                                                              svs_pkg::PH_VALVE_DOWN;
            end else if (sync_l) begin
               phase_in = svs_pkg::PH_HUNT;
            end
         end
         svs_pkg::PH_SEND_UP: begin
            if (clk_l) begin
               dat_out_in = shift_ff[0];
               shift_in   = shift_ff >> 1;
               index_in   = index_inc;
               clk_out_in = 1'b1;
               phase_in   = svs_pkg::PH_SEND_DOWN;
            end else if (sync_l) begin
               phase_in = svs_pkg::PH_HUNT;
            end
         end
         svs_pkg::PH_OP_DOWN: begin
            if (clk_l) begin
               if (sync_l) phase_in = svs_pkg::PH_HUNT;
            end else begin
               clk_out_in = 1'b0;
               if (index_ff >= svs_pkg::IndexWidth'(svs_pkg::OpcodeBits)) begin
                  // Opcode complete: decode it
                  if (shift_ff[svs_pkg::OpcodeBits-1:0] == svs_pkg::OpSetValves) begin
                     phase_in = svs_pkg::PH_VALVE_UP;
                     index_in = '0;
                     shift_in = '0;
                  end else if (shift_ff[svs_pkg::OpcodeBits-1:0] ==
                               svs_pkg::OpReadPressure) begin
                     phase_in = svs_pkg::PH_SEND_UP;
                     index_in = '0;
                     shift_in = reply_word;
                  end else begin
                     phase_in = svs_pkg::PH_HUNT;
                  end
               end else begin
                  phase_in = svs_pkg::PH_OP_UP;
               end
            end
         end
         svs_pkg::PH_VALVE_DOWN: begin
            if (clk_l) begin
               if (sync_l) phase_in = svs_pkg::PH_HUNT;
            end else begin
               clk_out_in = 1'b0;
               if (index_ff >= svs_pkg::IndexWidth'(VALVE_COUNT)) begin
                  valve_in = shift_ff[VALVE_COUNT-1:0];
                  phase_in = svs_pkg::PH_OP_UP;
                  index_in = '0;
                  shift_in = '0;
               end else begin
                  phase_in = svs_pkg::PH_VALVE_UP;
               end
            end
         end
         svs_pkg::PH_SEND_DOWN: begin
            if (clk_l) begin
               if (sync_l) phase_in = svs_pkg::PH_HUNT;
            end else begin
               clk_out_in = 1'b0;
               if (index_ff >= svs_pkg::IndexWidth'(svs_pkg::ReplyBits)) begin
                  phase_in = svs_pkg::PH_OP_UP;
                  index_in = '0;
                  shift_in = '0;
               end else begin
                  phase_in = svs_pkg::PH_SEND_UP;
               end
            end
         end
         default: begin
            // Sync hunt: sync alone active starts the sync sequence
            phase_in = svs_pkg::PH_HUNT;
            if (sync_l && !dat_l && !clk_l) begin
               dat_out_in = 1'b0;
               clk_out_in = 1'b0;
               phase_in   = svs_pkg::PH_SYNC_UP;
            end
         end
      endcase
   end

   // Link state advances once per accepted sample
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= svs_pkg::PH_HUNT;
         index_ff   <= '0;
         shift_ff   <= '0;
         valve_ff   <= '0;
         clk_out_ff <= 1'b0;
         dat_out_ff <= 1'b0;
      end else if (take) begin
         phase_ff   <= phase_in;
         index_ff   <= index_in;
         shift_ff   <= shift_in;
         valve_ff   <= valve_in;
         clk_out_ff <= clk_out_in;
         dat_out_ff <= dat_out_in;
      end
   end

   // Result reflects the state after this sample
   assign in_sync = (phase_in == svs_pkg::PH_OP_UP)    || (phase_in == svs_pkg::PH_OP_DOWN)
                 || (phase_in == svs_pkg::PH_VALVE_UP) || (phase_in == svs_pkg::PH_VALVE_DOWN)
                 || (phase_in == svs_pkg::PH_SEND_UP)  || (phase_in == svs_pkg::PH_SEND_DOWN);

   always_comb begin
      result.ack_clock    = clk_out_in;
      result.data_out     = dat_out_in;
      result.valve_states = svs_pkg::ShownValves'(valve_in);
      result.in_sync      = in_sync;
   end

endmodule

// ----- hw/rtl/svs_out_buf.sv -----
`timescale 1ns / 1ps

module svs_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  svs_pkg::rsp_item_type push_item,
   output logic                  space,
   output logic                  out_valid,
   input  logic                  out_ready,
   output svs_pkg::rsp_item_type out_item
);

   logic                  main_valid_ff, main_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   svs_pkg::rsp_item_type main_ff, main_in;
   svs_pkg::rsp_item_type skid_ff, skid_in;
   logic                  pop;

   assign pop       = main_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_item  = main_ff;

   // Main register feeds the port; the skid register catches a result
   // that arrives while the main one is stalled.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         main_valid_in = 1'b0;
      end
      if (pop && skid_valid_ff) begin
         main_in       = skid_ff;
         main_valid_in = 1'b1;
         skid_valid_in = 1'b0;
      end
      if (push) begin
         if (!main_valid_in) begin
            main_in       = push_item;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_item;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ----- hw/rtl/handshake_serial_valve_slave.sv -----
`timescale 1ns / 1ps

// Slave of a three-wire handshaked serial link that drives a valve bank and
// reports a pressure sample. Each transfer on req_ is one sample of the sync,
// clock and data pins plus the current converter result; each one yields
// exactly one transfer on rsp_ carrying the slave clock and data lane levels,
// the valve bits and the in-sync flag. One sample is accepted per clock cycle
// while the output buffer has space; a sample is held in the input register,
// goes through the single state update in the link state machine and is
// registered in the two-entry output buffer, which lets the block keep accepting
// while one result waits; req_tready falls only once both entries are full.

module handshake_serial_valve_slave #(
   parameter int VALVE_COUNT = svs_pkg::ValveCountDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata, lowest bit up: sync_line, clock_line, data_line,
   // pressure_sample[9:0], pressure_valid, zero fill
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [svs_pkg::ReqDataWidth-1:0]  req_tdata,
   // rsp_tdata, lowest bit up: ack_clock, data_out, valve_states[7:0],
   // in_sync, zero fill
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [svs_pkg::RspDataWidth-1:0]  rsp_tdata
);

   logic                  in_valid_ff, in_valid_in;
   svs_pkg::req_item_type in_item_ff;
   logic                  take;
   logic                  space;
   svs_pkg::rsp_item_type core_result;
   svs_pkg::rsp_item_type out_item;

   // Input register: holds one sample until the core takes it
   assign take        = in_valid_ff && space;
   assign req_tready  = !in_valid_ff || take;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= svs_pkg::req_item_type'(req_tdata[svs_pkg::ReqBits-1:0]);
      end
   end

   svs_core #(
      .VALVE_COUNT (VALVE_COUNT)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .item   (in_item_ff),
      .result (core_result)
   );

   svs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_item (core_result),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = svs_pkg::RspDataWidth'(out_item);

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import svs_pkg::*;

   localparam int ValveCount  = ValveCountDefault;
   localparam int DrainCycles = 8;
   localparam int CycleLimit  = 200000;
   localparam int MaxReports  = 10;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // req_tdata, lowest bit up: sync_line, clock_line, data_line,
   // pressure_sample[9:0], pressure_valid, zero fill
   logic [ReqDataWidth-1:0] req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // rsp_tdata, lowest bit up: ack_clock, data_out, valve_states[7:0],
   // in_sync, zero fill
   logic [RspDataWidth-1:0] rsp_tdata;

   handshake_serial_valve_slave #(
      .VALVE_COUNT(ValveCount)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // Predicted state of the slave link.
   phase_type             lk_phase;
   logic [IndexWidth-1:0] lk_index;
   logic [ShiftWidth-1:0] lk_shift;
   logic [15:0]           lk_valves;
   logic                  lk_clk;
   logic                  lk_dat;

   rsp_item_type expected_lanes[$];

   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int samples_sent   = 0;
   int results_seen   = 0;
   int mismatches     = 0;
   int cycle_count    = 0;
   int valve_writes   = 0;
   int pressure_reads = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Advance the predicted link by one pin sample and return the lane levels.
   function automatic rsp_item_type advance_link(input req_item_type it);
      rsp_item_type r;
      case (lk_phase)
         PH_SYNC_UP: begin
            if (it.clock_line) begin
               lk_clk   = 1'b1;
               lk_phase = PH_SYNC_DOWN;
            end else if (!it.sync_line || it.data_line) begin
               lk_phase = PH_HUNT;
            end
         end
         PH_SYNC_DOWN: begin
            if (it.clock_line) begin
               if (it.data_line) lk_phase = PH_HUNT;
            end else if (it.sync_line) begin
               lk_phase = PH_HUNT;
            end else begin
               lk_clk   = 1'b0;
               lk_phase = PH_OP_UP;
               lk_index = '0;
               lk_shift = '0;
            end
         end
         PH_OP_UP, PH_VALVE_UP: begin
            if (it.clock_line) begin
               if (it.data_line && lk_index < 16) lk_shift[lk_index[3:0]] = 1'b1;
               lk_index = lk_index + 1'b1;
               lk_clk   = 1'b1;
               lk_phase = phase_type'(lk_phase + 4'd1);
            end else if (it.sync_line) begin
               lk_phase = PH_HUNT;
            end
         end
         PH_SEND_UP: begin
            if (it.clock_line) begin
               lk_dat   = lk_shift[0];
               lk_shift = lk_shift >> 1;
               lk_index = lk_index + 1'b1;
               lk_clk   = 1'b1;
               lk_phase = PH_SEND_DOWN;
            end else if (it.sync_line) begin
               lk_phase = PH_HUNT;
            end
         end
         PH_OP_DOWN, PH_VALVE_DOWN, PH_SEND_DOWN: begin
            if (it.clock_line) begin
               if (it.sync_line) lk_phase = PH_HUNT;
            end else begin
               lk_clk = 1'b0;
               if (lk_phase == PH_OP_DOWN) begin
                  if (lk_index < OpcodeBits) begin
                     lk_phase = PH_OP_UP;
                  end else if (lk_shift[OpcodeBits-1:0] == OpSetValves) begin
                     lk_phase = PH_VALVE_UP;
                     lk_index = '0;
                     lk_shift = '0;
                  end else if (lk_shift[OpcodeBits-1:0] == OpReadPressure) begin
                     // The reply word is taken from the sample of this tick.
                     lk_shift = it.pressure_valid ?
                                (ShiftWidth'(it.pressure_sample) & SampleMask) : InvalidWord;
                     lk_index = '0;
                     lk_phase = PH_SEND_UP;
                  end else begin
                     lk_phase = PH_HUNT;
                  end
               end else if (lk_phase == PH_VALVE_DOWN) begin
                  if (lk_index >= ValveCount) begin
                     lk_valves = lk_shift & 16'((32'd1 << ValveCount) - 32'd1);
                     lk_phase  = PH_OP_UP;
                     lk_index  = '0;
                     lk_shift  = '0;
                  end else begin
                     lk_phase = PH_VALVE_UP;
                  end
               end else begin
                  if (lk_index >= ReplyBits) begin
                     lk_phase = PH_OP_UP;
                     lk_index = '0;
                     lk_shift = '0;
                  end else begin
                     lk_phase = PH_SEND_UP;
                  end
               end
            end
         end
         default: begin
            // Sync hunt: only sync alone starts a sequence.
            lk_phase = PH_HUNT;
            if (it.sync_line && !it.data_line && !it.clock_line) begin
               lk_dat   = 1'b0;
               lk_clk   = 1'b0;
               lk_phase = PH_SYNC_UP;
            end
         end
      endcase
      r.ack_clock    = lk_clk;
      r.data_out     = lk_dat;
      r.valve_states = lk_valves[ShownValves-1:0];
      r.in_sync      = (lk_phase >= PH_OP_UP) && (lk_phase <= PH_SEND_DOWN);
      return r;
   endfunction

   // Compare one result transfer with the oldest predicted lane levels.
   task automatic compare_lanes(input rsp_item_type got);
      rsp_item_type want;
      results_seen++;
      if (expected_lanes.size() == 0) begin
         mismatches++;
         if (mismatches <= MaxReports)
            $display("Result %0d arrived with nothing pending: %h", results_seen, got);
      end else begin
         want = expected_lanes.pop_front();
         if (got.ack_clock !== want.ack_clock || got.data_out !== want.data_out ||
             got.valve_states !== want.valve_states || got.in_sync !== want.in_sync) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display({"Result %0d: expected ack=%b dout=%b valves=%h sync=%b, ",
                         "got ack=%b dout=%b valves=%h sync=%b"},
                        results_seen, want.ack_clock, want.data_out, want.valve_states,
                        want.in_sync, got.ack_clock, got.data_out, got.valve_states,
                        got.in_sync);
         end
      end
   endtask

   // Result side: random stalls and checking of every accepted transfer.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) compare_lanes(rsp_tdata[RspBits-1:0]);
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Send one pin sample, with random idle cycles before it.
   task automatic send_tick(input req_item_type it);
      logic [ReqDataWidth-1:0] word;
      word = '0;
      word[ReqBits-1:0] = it;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_lanes.push_back(advance_link(it));
      samples_sent++;
   endtask

   // One tick of pin levels with a random converter result.
   task automatic drive_pins(input bit s, input bit c, input bit d);
      req_item_type it;
      it.sync_line  = s;
      it.clock_line = c;
      it.data_line  = d;
      case ($urandom_range(0, 7))
         0:       it.pressure_sample = '0;
         1:       it.pressure_sample = '1;
         default: it.pressure_sample = SampleWidth'($urandom);
      endcase
      it.pressure_valid = ($urandom_range(0, 3) != 0);
      send_tick(it);
   endtask

   // Pin levels held for one or two oversampled ticks.
   task automatic hold_pins(input bit s, input bit c, input bit d);
      repeat ($urandom_range(1, 2)) drive_pins(s, c, d);
   endtask

   task automatic master_sync();
      hold_pins(1'b0, 1'b0, 1'b0);
      hold_pins(1'b1, 1'b0, 1'b0);
      hold_pins(1'b1, 1'b1, 1'b0);
      if ($urandom_range(0, 1)) hold_pins(1'b0, 1'b1, 1'b0);
      hold_pins(1'b0, 1'b0, 1'b0);
   endtask

   // One bit handshake: clock up with the data level, then clock down.
   task automatic master_word(input logic [15:0] value, input int nbits);
      for (int i = 0; i < nbits; i++) begin
         hold_pins(1'b0, 1'b1, value[i]);
         hold_pins(1'b0, 1'b0, value[i]);
      end
   endtask

   task automatic cmd_set_valves();
      logic [7:0] v;
      case ($urandom_range(0, 3))
         0:       v = 8'h00;
         1:       v = 8'hFF;
         default: v = 8'($urandom);
      endcase
      master_word(16'(OpSetValves), OpcodeBits);
      master_word(16'(v), ValveCount);
      valve_writes++;
   endtask

   task automatic cmd_read_pressure();
      master_word(16'(OpReadPressure), OpcodeBits);
      master_word(16'($urandom), ReplyBits);
      pressure_reads++;
   endtask

   task automatic cmd_bad_opcode();
      logic [OpcodeBits-1:0] op;
      op = OpcodeBits'($urandom);
      while (op == OpSetValves || op == OpReadPressure) op = OpcodeBits'($urandom);
      master_word(16'(op), OpcodeBits);
      hold_pins(1'b0, 1'b0, 1'b0);
   endtask

   // Up to six bits, then sync raised while the slave waits on either clock edge.
   task automatic abort_transfer();
      bit d;
      master_word(16'($urandom), $urandom_range(0, 6));
      if ($urandom_range(0, 1)) begin
         hold_pins(1'b1, 1'b0, 1'b0);
      end else begin
         d = $urandom_range(0, 1);
         hold_pins(1'b0, 1'b1, d);
         hold_pins(1'b1, 1'b1, d);
      end
      hold_pins(1'b0, 1'b0, 1'b0);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(4, 16))
         drive_pins($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
   endtask

   // Hold the sender until every predicted result has been checked.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_lanes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Each way out of the sync sequence, plus clock and data seen in the hunt.
   task automatic test_sync_aborts();
      drive_pins(1'b1, 1'b1, 1'b0);
      drive_pins(1'b1, 1'b0, 1'b1);
      drive_pins(1'b1, 1'b0, 1'b0);
      drive_pins(1'b0, 1'b0, 1'b0);
      drive_pins(1'b1, 1'b0, 1'b0);
      drive_pins(1'b1, 1'b0, 1'b1);
      drive_pins(1'b1, 1'b0, 1'b0);
      drive_pins(1'b1, 1'b1, 1'b0);
      drive_pins(1'b1, 1'b1, 1'b1);
      drive_pins(1'b1, 1'b0, 1'b0);
      drive_pins(1'b1, 1'b1, 1'b0);
      drive_pins(1'b1, 1'b0, 1'b0);
      drive_pins(1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_unknown_opcode();
      master_sync();
      master_word(16'hFFFF, OpcodeBits);
      drive_pins(1'b0, 1'b0, 1'b0);
   endtask

   // Sync raised while the slave waits for the master clock to fall.
   task automatic test_sync_in_transfer();
      master_sync();
      drive_pins(1'b0, 1'b1, 1'b1);
      drive_pins(1'b1, 1'b1, 1'b1);
      drive_pins(1'b0, 1'b0, 1'b0);
      wait_drained();
   endtask

   // Mostly well-formed sessions, some noise and broken sequences.
   task automatic test_traffic(input int n_samples, input int idle, input int stall);
      int stop_at;
      int n_cmds;
      int choice;
      send_idle_pct = idle;
      stall_pct     = stall;
      stop_at       = samples_sent + n_samples;
      while (samples_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            send_noise();
         end else begin
            master_sync();
            n_cmds = $urandom_range(1, 5);
            for (int k = 0; k < n_cmds; k++) begin
               choice = $urandom_range(0, 9);
               if (choice < 4) begin
                  cmd_set_valves();
               end else if (choice < 8) begin
                  cmd_read_pressure();
               end else if (choice == 8) begin
                  cmd_bad_opcode();
                  break;
               end else begin
                  abort_transfer();
                  break;
               end
            end
         end
      end
      wait_drained();
   endtask

   initial begin
      lk_phase  = PH_HUNT;
      lk_index  = '0;
      lk_shift  = '0;
      lk_valves = '0;
      lk_clk    = 1'b0;
      lk_dat    = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_sync_aborts();
      test_unknown_opcode();
      test_sync_in_transfer();
      test_traffic(420, 0, 0);
      test_traffic(420, 76, 0);
      test_traffic(420, 0, 76);
      test_traffic(420, 23, 23);

      $display("Sent %0d pin samples over four idling phases: %0d valve writes, %0d reads.",
               samples_sent, valve_writes, pressure_reads);
      $display("Checked %0d result transfers field by field.", results_seen);
      if (mismatches == 0 && expected_lanes.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
